>>> src/rccc_pkg.sv
// ----------------------------------------------------------------------------
// rccc_pkg
// Types, widths and constants shared by the row cosine coherence checker.
// ----------------------------------------------------------------------------
package rccc_pkg;

  localparam int ACC_W  = 46;
  localparam int ALU_W  = 92;
  localparam int CNT_W  = 17;
  localparam int SUM_W  = 33;
  localparam int STEP_W = 6;

  localparam int PROD_STEPS = 46;
  localparam int SQRT_STEPS = 46;
  localparam int DIV_STEPS  = 15;
  localparam int MEAN_STEPS = 33;

  localparam logic signed [15:0] THRESH_RESET = 16'sd32440;
  localparam logic signed [15:0] Q15_ONE      = 16'sd32767;
  localparam logic signed [15:0] Q15_MIN      = -16'sd32768;
  localparam logic [CNT_W-1:0]   CNT_MAX      = {CNT_W{1'b1}};

  typedef struct packed {
    logic signed [15:0] value_a;
    logic signed [15:0] value_b;
    logic               end_of_row;
    logic               end_of_tensor;
  } rccc_in_t;

  typedef struct packed {
    logic [15:0]        row_index;
    logic signed [15:0] row_cosine;
    logic               row_flagged;
    logic signed [15:0] min_cos;
    logic [16:0]        flagged_count;
    logic signed [15:0] avg_cos;
    logic               tensor_done;
  } rccc_out_t;

  typedef struct packed {
    logic [ALU_W-1:0] x;
    logic [ALU_W-1:0] y;
    logic             sub;
  } rccc_alu_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAC,
    S_ZCHK,
    S_PROD,
    S_SQRT,
    S_DCHK,
    S_DIV,
    S_ROW,
    S_MEAN,
    S_OUT
  } rccc_state_t;

endpackage

>>> src/row_cosine_coherence_checker.sv
// ----------------------------------------------------------------------------
// row_cosine_coherence_checker
// Per-row cosine between two streamed matrices, with flagging, running
// minimum, flag count and end-of-tensor mean.
// ----------------------------------------------------------------------------
// operation: every element makes 3 passes through the one 16x16 multiplier;
//   an end-of-row result then uses the shared 92-bit adder for the 46-step
//   product, 46-step square root and 15-step division, unless a norm is zero
//   or the quotient saturates; end of tensor adds 33 mean steps
// flow: one item in flight; the next is taken after its passes and any result load
// reset: synchronous, clears all tensor state and sets the threshold to 32440
module row_cosine_coherence_checker
  import rccc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rccc_in_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rccc_out_t          out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic signed [15:0] cfg_data
);

  rccc_state_t state, state_next;

  logic [STEP_W-1:0] step;
  logic [1:0]        phase;

  logic signed [15:0] a_r, b_r;
  logic               eor_r, eot_r;

  logic signed [ACC_W-1:0] dot_acc;
  logic [ACC_W-1:0]        na_acc, nb_acc;

  logic [ALU_W-1:0]   prod;
  logic [ACC_W-1:0]   nb_sh;
  logic [ACC_W+2:0]   rem;
  logic [ACC_W-1:0]   root;
  logic [ACC_W-1:0]   drem;
  logic [DIV_STEPS-2:0] quo;
  logic signed [15:0] cos_r;

  logic [SUM_W-1:0]   msh;
  logic [CNT_W-1:0]   mrem;
  logic               mean_neg;

  logic [CNT_W-1:0]        row_counter;
  logic signed [SUM_W-1:0] cosine_sum;
  logic signed [15:0]      running_min;
  logic [CNT_W-1:0]        flag_counter;
  logic signed [15:0]      threshold;
  logic [15:0]             idx_r;
  logic                    flagged_r;

  rccc_alu_req_t    alu_req;
  logic [ALU_W-1:0] alu_res;
  logic             alu_ge;

  rccc_alu u_alu (
    .req   (alu_req),
    .res   (alu_res),
    .carry (alu_ge)
  );

  // multiplier pass: a*b, a*a, b*b
  logic signed [15:0]      mul_x, mul_y;
  logic signed [31:0]      mul_p;
  logic signed [ACC_W:0]   dsum;
  logic [ACC_W:0]          nsum;
  logic [ACC_W-1:0]        norm_sel;

  assign mul_x    = (phase == 2'd2) ? b_r : a_r;
  assign mul_y    = (phase == 2'd1) ? a_r : b_r;
  assign mul_p    = mul_x * mul_y;
  assign dsum     = (ACC_W+1)'(dot_acc) + (ACC_W+1)'(mul_p);
  assign norm_sel = (phase == 2'd1) ? na_acc : nb_acc;
  assign nsum     = {1'b0, norm_sel} + (ACC_W+1)'(mul_p[30:0]);

  logic signed [ACC_W-1:0] dot_sat;
  logic [ACC_W-1:0]        norm_sat;

  assign dot_sat  = (dsum[ACC_W] != dsum[ACC_W-1]) ?
                    {dsum[ACC_W], {(ACC_W-1){~dsum[ACC_W]}}} : dsum[ACC_W-1:0];
  assign norm_sat = nsum[ACC_W] ? {ACC_W{1'b1}} : nsum[ACC_W-1:0];

  logic             dot_neg;
  logic [ACC_W-1:0] dot_mag;

  assign dot_neg = dot_acc[ACC_W-1];
  assign dot_mag = dot_neg ? ACC_W'(-dot_acc) : ACC_W'(dot_acc);

  // square root and division operands
  logic [ACC_W+2:0] rem_sh;
  logic [ACC_W+1:0] trial;
  logic [ACC_W:0]   drem_sh;
  logic [CNT_W:0]   mrem_sh;
  logic [DIV_STEPS-1:0] qv;

  assign rem_sh  = {rem[ACC_W:0], prod[ALU_W-1 -: 2]};
  assign trial   = {root, 2'b01};
  assign drem_sh = {drem, 1'b0};
  assign mrem_sh = {mrem, msh[SUM_W-1]};
  assign qv      = {quo, alu_ge};

  // row statistics
  logic signed [SUM_W:0]   ssum;
  logic signed [SUM_W-1:0] sum_sat;
  logic                    row_flag;

  assign ssum     = (SUM_W+1)'(cosine_sum) + (SUM_W+1)'(cos_r);
  assign sum_sat  = (ssum[SUM_W] != ssum[SUM_W-1]) ?
                    {ssum[SUM_W], {(SUM_W-1){~ssum[SUM_W]}}} : ssum[SUM_W-1:0];
  assign row_flag = cos_r < threshold;

  logic signed [15:0] mean_val;

  always_comb begin
    if (mean_neg) begin
      mean_val = (msh > SUM_W'(32768)) ? Q15_MIN : -$signed(msh[15:0]);
    end else begin
      mean_val = (msh > SUM_W'(32767)) ? Q15_ONE : $signed(msh[15:0]);
    end
  end

  logic out_free;
  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_MAC;
      S_MAC: begin
        if (phase == 2'd2) state_next = eor_r ? S_ZCHK : S_IDLE;
      end
      S_ZCHK: begin
        state_next = (na_acc == '0 || nb_acc == '0) ? S_ROW : S_PROD;
      end
      S_PROD: if (step == STEP_W'(PROD_STEPS - 1)) state_next = S_SQRT;
      S_SQRT: if (step == STEP_W'(SQRT_STEPS - 1)) state_next = S_DCHK;
      S_DCHK: state_next = alu_ge ? S_ROW : S_DIV;
      S_DIV:  if (step == STEP_W'(DIV_STEPS - 1)) state_next = S_ROW;
      S_ROW:  state_next = eot_r ? S_MEAN : S_OUT;
      S_MEAN: if (step == STEP_W'(MEAN_STEPS - 1)) state_next = S_OUT;
      S_OUT:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // shared adder operands
  always_comb begin
    alu_req = '0;
    unique case (state)
      S_PROD: begin
        alu_req.x = {prod[ALU_W-2:0], 1'b0};
        alu_req.y = nb_sh[ACC_W-1] ? ALU_W'(na_acc) : '0;
      end
      S_SQRT: begin
        alu_req.x   = ALU_W'(rem_sh);
        alu_req.y   = ALU_W'(trial);
        alu_req.sub = 1'b1;
      end
      S_DCHK: begin
        alu_req.x   = ALU_W'(dot_mag);
        alu_req.y   = ALU_W'(root);
        alu_req.sub = 1'b1;
      end
      S_DIV: begin
        alu_req.x   = ALU_W'(drem_sh);
        alu_req.y   = ALU_W'(root);
        alu_req.sub = 1'b1;
      end
      S_MEAN: begin
        alu_req.x   = ALU_W'(mrem_sh);
        alu_req.y   = ALU_W'(row_counter);
        alu_req.sub = 1'b1;
      end
      default: alu_req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      threshold    <= THRESH_RESET;
      dot_acc      <= '0;
      na_acc       <= '0;
      nb_acc       <= '0;
      row_counter  <= '0;
      cosine_sum   <= '0;
      running_min  <= Q15_ONE;
      flag_counter <= '0;
      step         <= '0;
      phase        <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid) threshold <= cfg_data;
      if (state == S_OUT && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            a_r   <= in_data.value_a;
            b_r   <= in_data.value_b;
            eor_r <= in_data.end_of_row;
            eot_r <= in_data.end_of_tensor;
            phase <= '0;
          end
        end
        S_MAC: begin
          unique case (phase)
            2'd0:    dot_acc <= dot_sat;
            2'd1:    na_acc  <= norm_sat;
            default: nb_acc  <= norm_sat;
          endcase
          phase <= phase + 2'd1;
        end
        S_ZCHK: begin
          if (na_acc == '0 && nb_acc == '0) cos_r <= Q15_ONE;
          else cos_r <= '0;
          prod  <= '0;
          nb_sh <= nb_acc;
          step  <= '0;
        end
        S_PROD: begin
          prod  <= alu_res;
          nb_sh <= {nb_sh[ACC_W-2:0], 1'b0};
          step  <= step + 1'b1;
          rem   <= '0;
          root  <= '0;
          if (step == STEP_W'(PROD_STEPS - 1)) step <= '0;
        end
        S_SQRT: begin
          rem  <= alu_ge ? alu_res[ACC_W+2:0] : rem_sh;
          root <= {root[ACC_W-2:0], alu_ge};
          prod <= {prod[ALU_W-3:0], 2'b00};
          step <= step + 1'b1;
          if (step == STEP_W'(SQRT_STEPS - 1)) step <= '0;
        end
        S_DCHK: begin
          // quotient of at least one: saturate the cosine
          cos_r <= dot_neg ? Q15_MIN : Q15_ONE;
          drem  <= dot_mag;
          quo   <= '0;
          step  <= '0;
        end
        S_DIV: begin
          drem <= alu_ge ? alu_res[ACC_W-1:0] : drem_sh[ACC_W-1:0];
          quo  <= qv[DIV_STEPS-2:0];
          step <= step + 1'b1;
          if (step == STEP_W'(DIV_STEPS - 1)) begin
            step  <= '0;
            cos_r <= dot_neg ? -$signed({1'b0, qv}) : $signed({1'b0, qv});
          end
        end
        S_ROW: begin
          dot_acc    <= '0;
          na_acc     <= '0;
          nb_acc     <= '0;
          idx_r      <= row_counter[15:0];
          flagged_r  <= row_flag;
          cosine_sum <= sum_sat;
          if (row_counter != CNT_MAX) row_counter <= row_counter + 1'b1;
          if (cos_r < running_min) running_min <= cos_r;
          if (row_flag && flag_counter != CNT_MAX) flag_counter <= flag_counter + 1'b1;
          mean_neg <= sum_sat[SUM_W-1];
          msh      <= sum_sat[SUM_W-1] ? SUM_W'(-sum_sat) : SUM_W'(sum_sat);
          mrem     <= '0;
          step     <= '0;
        end
        S_MEAN: begin
          mrem <= alu_ge ? alu_res[CNT_W-1:0] : mrem_sh[CNT_W-1:0];
          msh  <= {msh[SUM_W-2:0], alu_ge};
          step <= step + 1'b1;
          if (step == STEP_W'(MEAN_STEPS - 1)) step <= '0;
        end
        S_OUT: begin
          if (out_free) begin
            out_data.row_index     <= idx_r;
            out_data.row_cosine    <= cos_r;
            out_data.row_flagged   <= flagged_r;
            out_data.min_cos       <= running_min;
            out_data.flagged_count <= flag_counter;
            out_data.avg_cos       <= eot_r ? mean_val : '0;
            out_data.tensor_done   <= eot_r;
            if (eot_r) begin
              row_counter  <= '0;
              cosine_sum   <= '0;
              running_min  <= Q15_ONE;
              flag_counter <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> state == S_IDLE && !out_valid)
    else $error("block not idle after reset");

  a_min_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.min_cos <= out_data.row_cosine)
    else $error("minimum cosine above row cosine");

  a_flag_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.row_flagged |-> out_data.flagged_count != '0)
    else $error("flagged row not counted");

  a_mean_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.tensor_done |-> out_data.avg_cos == '0)
    else $error("mean reported before end of tensor");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while previous one at work");

endmodule

>>> src/rccc_alu.sv
// ----------------------------------------------------------------------------
// rccc_alu
// Shared wide adder / subtractor; carry out of a subtract means x >= y.
// ----------------------------------------------------------------------------
module rccc_alu
  import rccc_pkg::*;
(
  input  rccc_alu_req_t    req,
  output logic [ALU_W-1:0] res,
  output logic             carry
);

  logic [ALU_W-1:0] y_op;

  assign y_op = req.sub ? ~req.y : req.y;
  assign {carry, res} = {1'b0, req.x} + {1'b0, y_op} + (ALU_W+1)'(req.sub);

endmodule

>>> sim/tb_row_cosine_coherence_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_row_cosine_coherence_checker
// Streams element pairs into the checker with random gaps and back-pressure,
// predicts every row result in the bench and compares the whole result with it.
// ----------------------------------------------------------------------------
module tb_row_cosine_coherence_checker
  import rccc_pkg::*;
();

  localparam longint DOT_HI  = 64'sd35184372088831;
  localparam longint DOT_LO  = -64'sd35184372088832;
  localparam longint NRM_HI  = 64'sd70368744177663;
  localparam longint CSUM_HI = 64'sd4294967295;
  localparam longint CSUM_LO = -64'sd4294967296;
  localparam int     CNT_TOP = 131071;

  typedef struct {
    rccc_in_t pair;
    int       gap;
  } pend_item_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  rccc_in_t           in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  rccc_out_t          out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic signed [15:0] cfg_data = '0;

  // bench copy of the block state
  longint             dot_sum, norm_a, norm_b, cos_total;
  int                 rows_seen, rows_flagged, low_cos;
  logic signed [15:0] threshold;

  pend_item_t pending[$];
  rccc_out_t  expected_rows[$];
  int         gap_left = 0;
  int         stall_left = 0;
  bit         calm = 1'b0;
  int         mismatches = 0;

  row_cosine_coherence_checker DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int idle_len();
    if (calm || $urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic longint unsigned root_of_product(longint unsigned x, longint unsigned y);
    logic [127:0] p;
    logic [127:0] sq;
    logic [63:0]  r;
    logic [63:0]  t;
    p = 128'(x) * 128'(y);
    r = '0;
    for (int k = 46; k >= 0; k--) begin
      t  = r | (64'd1 << k);
      sq = 128'(t) * 128'(t);
      if (sq <= p) r = t;
    end
    return r;
  endfunction

  function automatic int row_cosine_q15();
    longint unsigned s, mag, q;
    if (norm_a == 0 || norm_b == 0) return (norm_a == 0 && norm_b == 0) ? 32767 : 0;
    s = root_of_product(norm_a, norm_b);
    if (s == 0) s = 1;
    mag = (dot_sum < 0) ? -dot_sum : dot_sum;
    q = (mag << 15) / s;
    if (dot_sum < 0) return (q >= 32768) ? -32768 : -int'(q);
    return (q >= 32767) ? 32767 : int'(q);
  endfunction

  function automatic void clear_tensor();
    dot_sum = 0; norm_a = 0; norm_b = 0; cos_total = 0;
    rows_seen = 0; rows_flagged = 0; low_cos = 32767;
  endfunction

  function automatic void predict_row(rccc_in_t e);
    longint    a, b, d;
    int        c;
    int        idx;
    longint    m;
    rccc_out_t r;
    a = e.value_a;
    b = e.value_b;
    d = dot_sum + a * b;
    dot_sum = (d > DOT_HI) ? DOT_HI : ((d < DOT_LO) ? DOT_LO : d);
    norm_a = (norm_a + a * a > NRM_HI) ? NRM_HI : norm_a + a * a;
    norm_b = (norm_b + b * b > NRM_HI) ? NRM_HI : norm_b + b * b;
    if (!e.end_of_row) return;
    c = row_cosine_q15();
    dot_sum = 0; norm_a = 0; norm_b = 0;
    idx = rows_seen;
    if (rows_seen < CNT_TOP) rows_seen++;
    cos_total += c;
    if (cos_total > CSUM_HI) cos_total = CSUM_HI;
    if (cos_total < CSUM_LO) cos_total = CSUM_LO;
    if (c < low_cos) low_cos = c;
    r = '0;
    r.row_flagged = (c < threshold);
    if (r.row_flagged && rows_flagged < CNT_TOP) rows_flagged++;
    if (e.end_of_tensor) begin
      m = cos_total / rows_seen;
      r.avg_cos = (m > 32767) ? 16'sd32767 : ((m < -32768) ? Q15_MIN : 16'(m));
    end
    r.row_index     = 16'(idx);
    r.row_cosine    = 16'(c);
    r.min_cos       = 16'(low_cos);
    r.flagged_count = 17'(rows_flagged);
    r.tensor_done   = e.end_of_tensor;
    expected_rows.insert(expected_rows.size(), r);
    if (e.end_of_tensor) clear_tensor();
  endfunction

  // sender: accepted items go to the predictor, then the next item or a gap
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_row(in_data);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending.size() > 0) begin
          in_data  <= pending[0].pair;
          gap_left <= pending[0].gap;
          in_valid <= 1'b1;
          void'(pending.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: check each row result, stall at random
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_rows.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected row result %p", out_data);
        end else if (out_data !== expected_rows[0]) begin
          mismatches++;
          if (mismatches <= 10) begin
            $write("row mismatch (exp/got): idx %0d/%0d cos %0d/%0d flag %0d/%0d",
                   expected_rows[0].row_index, out_data.row_index,
                   expected_rows[0].row_cosine, out_data.row_cosine,
                   expected_rows[0].row_flagged, out_data.row_flagged);
            $display(" min %0d/%0d cnt %0d/%0d mean %0d/%0d done %0d/%0d",
                     expected_rows[0].min_cos, out_data.min_cos,
                     expected_rows[0].flagged_count, out_data.flagged_count,
                     expected_rows[0].avg_cos, out_data.avg_cos,
                     expected_rows[0].tensor_done, out_data.tensor_done);
          end
          void'(expected_rows.pop_front());
        end else begin
          void'(expected_rows.pop_front());
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else begin
        stall_left <= idle_len();
        out_ready  <= 1'b1;
      end
    end
  end

  function automatic void add_pair(int a, int b, bit eor, bit eot, int gap = -1);
    pend_item_t it;
    it.pair.value_a       = 16'(a);
    it.pair.value_b       = 16'(b);
    it.pair.end_of_row    = eor;
    it.pair.end_of_tensor = eot;
    it.gap = (gap < 0) ? idle_len() : gap;
    pending.insert(pending.size(), it);
  endfunction

  function automatic int pick_val(int mode);
    int pool[5] = '{-32768, 32767, 0, -1, 1};
    case (mode)
      0: return int'($signed(16'($urandom)));
      1: return pool[$urandom_range(0, 4)];
      default: return $urandom_range(0, 40) - 20;
    endcase
  endfunction

  // well-formed tensors with random content, plus stray end-of-tensor marks
  function automatic void add_random(int count);
    int n, len, mode, a, b;
    bit eot;
    n = 0;
    while (n < count) begin
      len  = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(9, 40);
      mode = $urandom_range(0, 5);
      eot  = ($urandom_range(0, 4) == 0);
      for (int k = 0; k < len; k++) begin
        a = pick_val(mode > 2 ? 0 : mode);
        b = pick_val(mode > 2 ? 0 : mode);
        // near-parallel rows land around the flag threshold
        if (mode >= 3) b = a + $urandom_range(0, 2 ** (2 * mode - 5)) - 2 ** (2 * mode - 6);
        if (b > 32767) b = 32767;
        if (b < -32768) b = -32768;
        if ($urandom_range(0, 19) == 0) mode = $urandom_range(0, 5);
        add_pair(a, b, k == len - 1, (k == len - 1) ? eot : ($urandom_range(0, 19) == 0));
        n++;
      end
    end
  endfunction

  task automatic wait_idle();
    while (pending.size() > 0 || in_valid || expected_rows.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_threshold(logic signed [15:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    threshold = v;
  endtask

  initial begin
    clear_tensor();
    threshold = THRESH_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, zero norms, stray end of tensor
    add_pair(32767, 32767, 1, 0);
    add_pair(-32768, -32768, 1, 0);
    add_pair(-32768, 32767, 1, 0);
    add_pair(32767, -32768, 1, 0);
    add_pair(0, 0, 1, 0);
    add_pair(5, 0, 1, 0);
    add_pair(0, -7, 1, 0);
    add_pair(3, 4, 0, 1);
    add_pair(1, 1, 1, 0);
    add_pair(100, -50, 0, 0);
    add_pair(200, 70, 1, 1);
    add_pair(-1, 1, 1, 0);
    add_pair(-32768, 0, 0, 0);
    add_pair(0, 32767, 1, 1);
    wait_idle();

    // one back-to-back row of opposite extreme values
    calm = 1'b1;
    for (int k = 0; k < 24; k++) add_pair(-32768, 32767, k == 23, k == 23, 0);
    wait_idle();
    calm = 1'b0;

    add_random(380);
    write_threshold(Q15_MIN);
    add_random(380);
    write_threshold(Q15_ONE);
    add_random(380);
    write_threshold(16'sd0);
    calm = 1'b1;
    add_random(200);
    wait_idle();
    calm = 1'b0;
    add_random(180);
    write_threshold(16'($urandom_range(29000, 32767)));
    add_random(380);

    wait_idle();
    repeat (150) @(posedge clk);
    if (mismatches == 0 && expected_rows.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #(64'd80_000_000);
    $display("Regression FAIL");
    $finish;
  end

endmodule

>>> filelist.f
src/rccc_pkg.sv
src/rccc_alu.sv
src/row_cosine_coherence_checker.sv
sim/tb_row_cosine_coherence_checker.sv
